>>> hw/rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg: shared types and constants for the WebSocket frame receiver
// Holds the stage transfer structs and the length codes of the frame header.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Number of bytes in each form of the extended length field.
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  // One registered input byte on its way to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] in_byte;
  } in_stage_t;

  // One result of the parser.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/wsfr_input_stage.sv
// ----------------------------------------------------------------------------
// wsfr_input_stage: input register of the frame receiver
// Captures one received byte per transfer and holds it while the pipe is held.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_input_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic                 in_valid,
  input  wire logic [7:0]           in_byte,
  output wsfr_pkg::in_stage_t       stage
);
  import wsfr_pkg::*;

  // The register moves on whenever the whole pipe advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage.valid <= in_valid;
    end
    if (advance) begin
      stage.in_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wsfr_parser.sv
// ----------------------------------------------------------------------------
// wsfr_parser: frame state machine and result register
// Walks the header, extended length and masking key, then unmasks the payload.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire wsfr_pkg::in_stage_t  stage,
  output logic                      out_valid,
  output wsfr_pkg::result_t         result
);
  import wsfr_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_EXTLEN  = 2'd1,
    PH_KEY     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  field_byte_count, field_byte_count_next;
  logic [63:0] payload_remaining, payload_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic        masked_flag, masked_flag_next;
  logic        final_flag, final_flag_next;
  logic [3:0]  extended_length_bytes, extended_length_bytes_next;
  logic [1:0]  mask_index, mask_index_next;
  logic        res_valid;
  result_t     res;

  // Next state and result for the byte held in the input register.
  always_comb begin
    logic [6:0] len7;
    logic [2:0] cnt_inc;
    logic       start_payload;
    logic [7:0] key_byte;

    phase_next                 = phase;
    field_byte_count_next      = field_byte_count;
    payload_remaining_next     = payload_remaining;
    mask_key_next              = mask_key;
    masked_flag_next           = masked_flag;
    final_flag_next            = final_flag;
    extended_length_bytes_next = extended_length_bytes;
    mask_index_next            = mask_index;
    res_valid                  = 1'b0;
    res                        = '0;
    start_payload              = 1'b0;
    len7                       = stage.in_byte[6:0];
    cnt_inc                    = field_byte_count + 3'd1;
    key_byte                   = mask_key[8 * mask_index +: 8];

    unique case (phase)
      PH_HEADER: begin
        if (field_byte_count == 3'd0) begin
          final_flag_next       = stage.in_byte[7];
          field_byte_count_next = 3'd1;
        end else begin
          masked_flag_next       = stage.in_byte[7];
          field_byte_count_next  = 3'd0;
          payload_remaining_next = '0;
          if (len7 == LEN_CODE_16) begin
            extended_length_bytes_next = EXT_BYTES_16;
            phase_next                 = PH_EXTLEN;
          end else if (len7 == LEN_CODE_64) begin
            extended_length_bytes_next = EXT_BYTES_64;
            phase_next                 = PH_EXTLEN;
          end else begin
            payload_remaining_next = {57'd0, len7};
            if (stage.in_byte[7]) begin
              phase_next = PH_KEY;
            end else begin
              start_payload = 1'b1;
            end
          end
        end
      end
      PH_EXTLEN: begin
        payload_remaining_next = {payload_remaining[55:0], stage.in_byte};
        field_byte_count_next  = cnt_inc;
        if (({1'b0, cnt_inc} == extended_length_bytes) ||
            (cnt_inc == 3'd0 && extended_length_bytes == EXT_BYTES_64)) begin
          field_byte_count_next = 3'd0;
          if (masked_flag) begin
            phase_next = PH_KEY;
          end else begin
            start_payload = 1'b1;
          end
        end
      end
      PH_KEY: begin
        mask_key_next[8 * field_byte_count[1:0] +: 8] = stage.in_byte;
        if (field_byte_count[1:0] == 2'd3) begin
          start_payload = 1'b1;
        end else begin
          field_byte_count_next = {1'b0, field_byte_count[1:0] + 2'd1};
        end
      end
      PH_PAYLOAD: begin
        payload_remaining_next = payload_remaining - 64'd1;
        mask_index_next        = mask_index + 2'd1;
        res_valid              = 1'b1;
        res.byte_valid         = 1'b1;
        res.data_byte          = masked_flag ? (stage.in_byte ^ key_byte) : stage.in_byte;
        if (payload_remaining == 64'd1) begin
          phase_next            = PH_HEADER;
          field_byte_count_next = 3'd0;
          res.end_of_message    = final_flag;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // Entry to the payload; an empty frame completes here at once.
    if (start_payload) begin
      field_byte_count_next = 3'd0;
      mask_index_next       = 2'd0;
      if (payload_remaining_next != 64'd0) begin
        phase_next = PH_PAYLOAD;
      end else begin
        phase_next = PH_HEADER;
        if (final_flag_next) begin
          res_valid          = 1'b1;
          res.end_of_message = 1'b1;
        end
      end
    end
  end

  // Frame state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_HEADER;
      field_byte_count      <= 3'd0;
      payload_remaining     <= '0;
      mask_key              <= '0;
      masked_flag           <= 1'b0;
      final_flag            <= 1'b0;
      extended_length_bytes <= 4'd0;
      mask_index            <= 2'd0;
      out_valid             <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.valid && res_valid;
      if (stage.valid) begin
        phase                 <= phase_next;
        field_byte_count      <= field_byte_count_next;
        payload_remaining     <= payload_remaining_next;
        mask_key              <= mask_key_next;
        masked_flag           <= masked_flag_next;
        final_flag            <= final_flag_next;
        extended_length_bytes <= extended_length_bytes_next;
        mask_index            <= mask_index_next;
      end
    end
    if (advance) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver: WebSocket frame parser and payload unmasker
// Takes a frame byte stream and returns unmasked payload bytes and end markers.
// ----------------------------------------------------------------------------
// The receiver takes one frame byte per clock while in_stall is low, and each
// byte goes through the input register and then the result register. Header,
// length and key bytes give no result; each payload byte gives one, and a
// final frame with an empty payload gives a lone end marker with byte_valid
// low. The rate is set by the frame state update, which handles one byte
// between the input register and the result register. A held result holds the
// whole two-stage pipe, so in_stall rises only while out_stall holds a result.
`default_nettype none

module websocket_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic            end_of_message
);
  import wsfr_pkg::*;

  logic      advance;
  in_stage_t stage;
  result_t   result;

  // The pipe moves unless a waiting result is being held.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  wsfr_input_stage u_input_stage (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .stage    (stage)
  );

  wsfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .stage     (stage),
    .out_valid (out_valid),
    .result    (result)
  );

  assign data_byte      = result.data_byte;
  assign byte_valid     = result.byte_valid;
  assign end_of_message = result.end_of_message;

endmodule

`default_nettype wire

>>> hw/rtl/wsfr_checker.sv
// ----------------------------------------------------------------------------
// wsfr_checker: port-level checks for the frame receiver
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_valid,
  input  wire logic       end_of_message
);

  // A held result stays in place with its fields unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) &&
      $stable(byte_valid) && $stable(end_of_message))
    else $error("held result changed");

  // The input is held back only while a result is held at the output.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A result without a payload byte is always an end marker.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> end_of_message)
    else $error("empty result without end marker");

  // A result without a payload byte carries a zero data byte.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == 8'd0)
    else $error("empty result with nonzero data");

  // A transfer in while the input stage is held cannot happen.
  a_no_accept_on_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && $past(out_valid && out_stall) && out_stall && out_valid |-> in_stall)
    else $error("input taken while the pipe is held");

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .data_byte      (data_byte),
  .byte_valid     (byte_valid),
  .end_of_message (end_of_message)
);

`default_nettype wire
